>>> rtl/core/mlcr_pkg.sv
// Shared types and constants for the midpoint line color raster core.
// No dependencies; imported by every module of the core.
`default_nettype none

package mlcr_pkg;

   // Fixed field widths of the stream payload
   localparam int COORD_FIELD_W = 5;
   localparam int COLOR_W       = 8;
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 40;

   // One restoring-division step per color bit
   localparam int DIV_STEPS = COLOR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Request payload bit positions
   localparam int REQ_START_X_LSB = 0;
   localparam int REQ_START_Y_LSB = 5;
   localparam int REQ_END_X_LSB   = 10;
   localparam int REQ_END_Y_LSB   = 15;
   localparam int REQ_START_R_LSB = 20;
   localparam int REQ_START_G_LSB = 28;
   localparam int REQ_START_B_LSB = 36;
   localparam int REQ_END_R_LSB   = 44;
   localparam int REQ_END_G_LSB   = 52;
   localparam int REQ_END_B_LSB   = 60;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   typedef struct packed {
      logic load;      // capture a new line
      logic div_step;  // one division step in every color lane
      logic advance;   // move to the next pixel
   } cmd_type;

   typedef struct packed {
      logic last;      // current pixel is the final one of the line
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/midpoint_line_color_raster_core.sv
// Top level of the midpoint line color raster core.
// Depends on mlcr_pkg, mlcr_ctrl and mlcr_datapath.
`default_nettype none

// Each request transfer carries two grid endpoints and their RGB colors; the core
// answers with one response transfer per pixel of the midpoint (Bresenham)
// line from the first endpoint to the second, in any octant, steps+1 pixels
// where steps = max(|dx|,|dy|). Each pixel's channels are
// c0 + trunc(k*(c1-c0)/steps); a single-point line returns the start color.
// The final pixel of a line has rsp_tlast set. For each line the request is
// captured, then the bit-per-cycle divider splits each color difference
// into a per-pixel quotient and remainder, then one pixel is output per
// cycle while the response side does not stall. A new request is taken
// only after the last pixel of the current line has been transferred.
// Only the low COORD_BITS bits of each coordinate are used.
module midpoint_line_color_raster_core
   import mlcr_pkg::*;
#(
   parameter int COORD_BITS = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: start_x, start_y, end_x, end_y, start_red, start_green,
   // start_blue, end_red, end_green, end_blue, then zero fill
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // response: pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
   // then zero fill; rsp_tlast is last_pixel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   // Sequence capture, division and pixel output
   mlcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold line geometry and color state; advance one pixel per transfer
   mlcr_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_tdata),
      .status   (status),
      .rsp_data (rsp_tdata)
   );

   assign rsp_tlast = status.last;

endmodule

`default_nettype wire

>>> rtl/core/mlcr_color_lane.sv
// One color channel: per-line step divider and incremental interpolation.
// Depends on mlcr_pkg.
`default_nettype none

module mlcr_color_lane
   import mlcr_pkg::*;
#(
   parameter int COORD_BITS = 5
) (
   input  wire logic                  clock,
   input  wire cmd_type               cmd,
   input  wire logic [COLOR_W-1:0]    start_color,
   input  wire logic [COLOR_W-1:0]    end_color,
   input  wire logic [COORD_BITS-1:0] steps,
   output logic      [COLOR_W-1:0]    color
);

   logic [COLOR_W-1:0]    col_ff, col_in;
   logic                  neg_ff, neg_in;
   logic [COLOR_W-1:0]    quo_ff, quo_in;   // dividend, then quotient
   logic [COORD_BITS-1:0] rem_ff, rem_in;   // partial, then final remainder
   logic [COORD_BITS-1:0] acc_ff, acc_in;   // running remainder of k*delta

   logic [COORD_BITS:0]   trial;
   logic                  trial_ge;
   logic [COORD_BITS:0]   acc_sum;
   logic                  acc_wrap;
   logic [COLOR_W-1:0]    inc;

   always_comb begin
      trial    = {rem_ff, quo_ff[COLOR_W-1]};
      trial_ge = trial >= {1'b0, steps};
      acc_sum  = {1'b0, acc_ff} + {1'b0, rem_ff};
      acc_wrap = acc_sum >= {1'b0, steps};
      inc      = quo_ff + COLOR_W'(acc_wrap);

      col_in = col_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         col_in = start_color;
         neg_in = end_color < start_color;
         quo_in = (end_color < start_color) ? start_color - end_color
                                            : end_color - start_color;
         rem_in = '0;
         acc_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[COLOR_W-2:0], trial_ge};
         rem_in = trial_ge ? COORD_BITS'(trial - {1'b0, steps})
                           : trial[COORD_BITS-1:0];
      end else if (cmd.advance) begin
         acc_in = acc_wrap ? COORD_BITS'(acc_sum - {1'b0, steps})
                           : acc_sum[COORD_BITS-1:0];
         col_in = neg_ff ? col_ff - inc : col_ff + inc;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign color = col_ff;

endmodule

`default_nettype wire

>>> rtl/core/mlcr_datapath.sv
// Datapath: line setup, midpoint stepper and three color lanes.
// Depends on mlcr_pkg and mlcr_color_lane.
`default_nettype none

module mlcr_datapath
   import mlcr_pkg::*;
#(
   parameter int COORD_BITS = 5
) (
   input  wire logic                    clock,
   input  wire cmd_type                 cmd,
   input  wire logic [REQ_DATA_W-1:0]   req_data,
   output status_type                   status,
   output logic      [RSP_DATA_W-1:0]   rsp_data
);

   localparam int DW = COORD_BITS + 3;

   logic [COORD_BITS-1:0] x0, y0, x1, y1;
   logic                  xneg, yneg, xmaj;
   logic [COORD_BITS-1:0] adx, ady, major, minor;
   logic signed [DW-1:0]  d_init, two_minor, two_diff;

   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic                  xneg_ff, yneg_ff, xmaj_ff;
   logic [COORD_BITS-1:0] steps_ff, steps_in, left_ff, left_in;
   logic signed [DW-1:0]  d_ff, d_in, inc_s_ff, inc_d_ff;
   logic [COORD_BITS-1:0] x_step, y_step;

   logic [COLOR_W-1:0]    red, green, blue;

   always_comb begin
      x0 = req_data[REQ_START_X_LSB +: COORD_BITS];
      y0 = req_data[REQ_START_Y_LSB +: COORD_BITS];
      x1 = req_data[REQ_END_X_LSB   +: COORD_BITS];
      y1 = req_data[REQ_END_Y_LSB   +: COORD_BITS];
      xneg  = x1 < x0;
      yneg  = y1 < y0;
      adx   = xneg ? x0 - x1 : x1 - x0;
      ady   = yneg ? y0 - y1 : y1 - y0;
      xmaj  = adx > ady;
      major = xmaj ? adx : ady;
      minor = xmaj ? ady : adx;
      two_minor = signed'(DW'({minor, 1'b0}));
      d_init    = two_minor - signed'(DW'(major));
      two_diff  = two_minor - signed'(DW'({major, 1'b0}));
   end

   always_comb begin
      x_step   = xneg_ff ? x_ff - 1'b1 : x_ff + 1'b1;
      y_step   = yneg_ff ? y_ff - 1'b1 : y_ff + 1'b1;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      left_in  = left_ff;
      steps_in = steps_ff;
      if (cmd.load) begin
         x_in     = x0;
         y_in     = y0;
         d_in     = d_init;
         left_in  = major;
         steps_in = major;
      end else if (cmd.advance) begin
         left_in = left_ff - 1'b1;
         if (d_ff < 0) begin
            // straight move along the major axis
            d_in = d_ff + inc_s_ff;
            if (xmaj_ff) begin
               x_in = x_step;
            end else begin
               y_in = y_step;
            end
         end else begin
            // diagonal move
            d_in = d_ff + inc_d_ff;
            x_in = x_step;
            y_in = y_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      left_ff  <= left_in;
      steps_ff <= steps_in;
      if (cmd.load) begin
         xneg_ff  <= xneg;
         yneg_ff  <= yneg;
         xmaj_ff  <= xmaj;
         inc_s_ff <= two_minor;
         inc_d_ff <= two_diff;
      end
   end

   mlcr_color_lane #(.COORD_BITS(COORD_BITS)) u_red (
      .clock       (clock),
      .cmd         (cmd),
      .start_color (req_data[REQ_START_R_LSB +: COLOR_W]),
      .end_color   (req_data[REQ_END_R_LSB +: COLOR_W]),
      .steps       (steps_ff),
      .color       (red)
   );

   mlcr_color_lane #(.COORD_BITS(COORD_BITS)) u_green (
      .clock       (clock),
      .cmd         (cmd),
      .start_color (req_data[REQ_START_G_LSB +: COLOR_W]),
      .end_color   (req_data[REQ_END_G_LSB +: COLOR_W]),
      .steps       (steps_ff),
      .color       (green)
   );

   mlcr_color_lane #(.COORD_BITS(COORD_BITS)) u_blue (
      .clock       (clock),
      .cmd         (cmd),
      .start_color (req_data[REQ_START_B_LSB +: COLOR_W]),
      .end_color   (req_data[REQ_END_B_LSB +: COLOR_W]),
      .steps       (steps_ff),
      .color       (blue)
   );

   assign status.last = left_ff == '0;

   assign rsp_data = {6'd0, blue, green, red,
                      COORD_FIELD_W'(y_ff), COORD_FIELD_W'(x_ff)};

endmodule

`default_nettype wire

>>> rtl/core/mlcr_ctrl.sv
// Controller: sequences line capture, color division and pixel output.
// Depends on mlcr_pkg.
`default_nettype none

module mlcr_ctrl
   import mlcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_EMIT;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.advance  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire
